[design/dopq_pkg.sv]
// Shared types and constants for the date-ordered priority queue.
// Depends on nothing; every other design file imports it.
package dopq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATE_W      = 32;
  localparam int AMOUNT_W    = 32;
  localparam int TAG_W       = 16;
  localparam int OCC_W       = 5;
  localparam int STATUS_W    = 2;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATE_W-1:0]   date;
    logic [AMOUNT_W-1:0] amount;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATE_W-1:0] key;
  } cell_ctl_t;

endpackage

[design/dopq_if.sv]
// Valid/ready channel interfaces for the queue's operation and result beats.
// Depends on dopq_pkg for field widths.
interface dopq_in_if;
  import dopq_pkg::*;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [DATE_W-1:0]   date_key;
  logic [AMOUNT_W-1:0] amount_cents;
  logic [TAG_W-1:0]    tag;

  modport source (output valid, operation, date_key, amount_cents, tag, input ready);
  modport sink   (input valid, operation, date_key, amount_cents, tag, output ready);
endinterface

interface dopq_out_if;
  import dopq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                head_valid;
  logic [DATE_W-1:0]   head_date;
  logic [AMOUNT_W-1:0] head_amount;
  logic [TAG_W-1:0]    head_tag;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, head_valid, head_date, head_amount, head_tag,
                  occupancy, input ready);
  modport sink   (input valid, status, head_valid, head_date, head_amount, head_tag,
                  occupancy, output ready);
endinterface

[design/dopq_cell.sv]
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on dopq_pkg for entry and control types.
module dopq_cell import dopq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  logic      valid,
  input  entry_t    left_entry,
  input  logic      left_before,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      ahead
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Flag a held entry that stays ahead of the new key
  assign ahead = valid && (entry_r.date < ctl.key);

  // Keep, take the new entry, shift right on insert, or shift left on remove
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (!ahead) begin
        entry_nxt = left_before ? new_entry : left_entry;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[design/dopq_chain.sv]
// Row of QUEUE_DEPTH cells kept in ascending date order, head at cell 0.
// Depends on dopq_pkg and dopq_cell.
module dopq_chain import dopq_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  entry_t           new_entry,
  input  logic [CNT_W-1:0] count,
  output entry_t           head
);

  entry_t entries [QUEUE_DEPTH];
  logic   befores [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_b;
    entry_t right_e;

    // Tie the chain ends: cell 0 always sees a slot boundary on its left
    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_b = befores[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    dopq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .valid       (CNT_W'(i) < count),
      .left_entry  (left_e),
      .left_before (left_b),
      .right_entry (right_e),
      .entry       (entries[i]),
      .ahead       (befores[i])
    );
  end

  assign head = entries[0];

endmodule

[design/date_ordered_priority_queue.sv]
// Top level of the date-ordered priority queue: control, occupancy, result register.
// Depends on dopq_pkg, dopq_if and dopq_chain.
//
// Usage:
//   in_ch carries one operation per beat: insert (date_key, amount_cents, tag)
//   or remove of the earliest entry. out_ch returns one result beat per
//   operation: status, head entry (removed entry on remove, earliest held
//   entry on insert) and occupancy after the operation.
//   Entries with equal dates leave in reverse order of arrival among
//   themselves (last in, first out): a new entry goes ahead of all
//   held entries with the same date.
// Timing and throughput:
//   A result is registered and appears in the cycle after its operation beat. Every cell of the
//   chain compares its date with the new key and moves in the same cycle,
//   so one operation per cycle is taken while the result register drains.
// Reset:
//   rst_n (synchronous, active low) empties the queue and the result register.
// Stall:
//   While out_ch is stalled with a result waiting, in_ch.ready is low and the
//   queue holds; no result is dropped or repeated.
module date_ordered_priority_queue import dopq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dopq_in_if.sink    in_ch,
  dopq_out_if.source out_ch
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic             head_valid_r, head_valid_nxt;
  entry_t           head_r, head_nxt;

  logic      accept;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    chain_head;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);

  assign new_entry.date   = in_ch.date_key;
  assign new_entry.amount = in_ch.amount_cents;
  assign new_entry.tag    = in_ch.tag;

  // Broadcast the command to the chain
  assign ctl.ins = accept && (in_ch.operation == OP_INSERT) && !full;
  assign ctl.rem = accept && (in_ch.operation == OP_REMOVE) && !empty;
  assign ctl.key = in_ch.date_key;

  dopq_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .new_entry (new_entry),
    .count     (count_r),
    .head      (chain_head)
  );

  // Build the result beat and the next occupancy
  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    status_nxt     = status_r;
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (in_ch.operation == OP_INSERT) begin
        head_valid_nxt = 1'b1;
        if (full) begin
          status_nxt = ST_FULL;
          head_nxt   = chain_head;
        end else begin
          status_nxt = ST_OK;
          count_nxt  = count_r + CNT_W'(1);
          head_nxt   = (empty || (in_ch.date_key <= chain_head.date)) ? new_entry
                                                                       : chain_head;
        end
      end else begin
        if (empty) begin
          status_nxt     = ST_EMPTY;
          head_valid_nxt = 1'b0;
          head_nxt       = '0;
        end else begin
          status_nxt     = ST_OK;
          head_valid_nxt = 1'b1;
          count_nxt      = count_r - CNT_W'(1);
          head_nxt       = chain_head;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    head_valid_r <= head_valid_nxt;
    head_r       <= head_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.head_valid  = head_valid_r;
  assign out_ch.head_date   = head_r.date;
  assign out_ch.head_amount = head_r.amount;
  assign out_ch.head_tag    = head_r.tag;
  assign out_ch.occupancy   = OCC_W'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == OP_INSERT && full) |=> $stable(count_r))
    else $error("rejected insert changed occupancy");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == OP_REMOVE && empty) |=>
      (status_r == ST_EMPTY && !head_valid_r))
    else $error("remove on empty not reported");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !ctl.ins && !ctl.rem)
    else $error("chain moved while result stalled");
`endif

endmodule
